// File: hw/rtl/gps_heartbeat_frame_scheduler_unit_defines.svh
// Assertion macros shared by the checker.
`ifndef GPS_HEARTBEAT_FRAME_SCHEDULER_UNIT_DEFINES_SVH
`define GPS_HEARTBEAT_FRAME_SCHEDULER_UNIT_DEFINES_SVH

// Checked only while out of reset.
`define GHFS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked also across reset.
`define GHFS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/ghfs_pkg.sv
package ghfs_pkg;

  // opcodes
  localparam logic [1:0] OP_POLL    = 2'd0;
  localparam logic [1:0] OP_FIX     = 2'd1;
  localparam logic [1:0] OP_SECONDS = 2'd2;

  // frame kinds
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_TIME = 2'd1;
  localparam logic [1:0] KIND_FIX  = 2'd2;

  // payload lengths
  localparam logic [2:0] LEN_NONE = 3'd0;
  localparam logic [2:0] LEN_TIME = 3'd5;
  localparam logic [2:0] LEN_FIX  = 3'd6;

  // sequencer steps
  localparam logic [1:0] STEP_LAT   = 2'd0;
  localparam logic [1:0] STEP_LON   = 2'd1;
  localparam logic [1:0] STEP_HGT   = 2'd2;
  localparam logic [1:0] STEP_STRAY = 2'd3;

  // register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_ID     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIX_ID      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CMD_ID      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_PERIOD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FIX_PERIOD  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FIX_GAP     = 3'd5;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [31:0]        tick_now;
    logic               rx_present;
    logic [31:0]        rx_frame_id;
    logic               fix_good;
    logic signed [7:0]  fix_status;
    logic [1:0]         fix_kind;
    logic [4:0]         satellites;
    logic signed [31:0] latitude;
    logic signed [31:0] longitude;
    logic signed [31:0] height;
    logic [31:0]        seconds_count;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  frame_kind;
    logic [31:0] frame_id;
    logic [2:0]  frame_length;
    logic [47:0] frame_payload;
    logic        activity;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [31:0] time_id;
    logic [31:0] fix_id;
    logic [31:0] cmd_id;
    logic [30:0] time_period;
    logic [30:0] fix_period;
    logic [30:0] fix_gap;
  } cfg_t;

  // one or two results per processed poll
  typedef struct packed {
    logic a;
    logic b;
  } push_t;

endpackage

// File: hw/rtl/gps_heartbeat_frame_scheduler_unit.sv
// Path: an accepted item waits in the core's input register until the result queue
//   has room; its results are then written into the queue, which raises out_valid.
// Throughput: one item per cycle unless input stalls; a poll with time and fix
//   frames gives two results, and input stalls while the result queue (QUEUE_DEPTH)
//   has fewer than two free entries.
// Reset: synchronous, active low; clears config registers, deadlines, step,
//   fix buffer, seconds count and the result queue.
module gps_heartbeat_frame_scheduler_unit #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input item channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  ghfs_pkg::in_item_t             in_data,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output ghfs_pkg::out_item_t            out_data,
  // register writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ghfs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data
);
  import ghfs_pkg::*;

  cfg_t      cfg;
  logic      room;
  push_t     push;
  out_item_t res_a, res_b;

  // Register file; writes are always taken (ready held high).
  ghfs_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Input register plus all scheduler state. An item in the register is
  // processed in one pass as soon as the queue has room for two results:
  // deadline checks, frame assembly and state update happen together.
  ghfs_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .room     (room),
    .push     (push),
    .res_a    (res_a),
    .res_b    (res_b)
  );

  // Result queue: takes up to two results a cycle, hands out one per transfer.
  ghfs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .res_a     (res_a),
    .res_b     (res_b),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: hw/rtl/ghfs_regs.sv
module ghfs_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ghfs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  output ghfs_pkg::cfg_t                cfg
);
  import ghfs_pkg::*;

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TIME_ID:     cfg_r.time_id     <= cfg_data;
        REG_FIX_ID:      cfg_r.fix_id      <= cfg_data;
        REG_CMD_ID:      cfg_r.cmd_id      <= cfg_data;
        REG_TIME_PERIOD: cfg_r.time_period <= cfg_data[30:0];
        REG_FIX_PERIOD:  cfg_r.fix_period  <= cfg_data[30:0];
        REG_FIX_GAP:     cfg_r.fix_gap     <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

endmodule

// File: hw/rtl/ghfs_core.sv
module ghfs_core (
  input  logic                clk,
  input  logic                rst_n,
  input  ghfs_pkg::cfg_t      cfg,
  input  logic                in_valid,
  output logic                in_stall,
  input  ghfs_pkg::in_item_t  in_data,
  input  logic                room,
  output ghfs_pkg::push_t     push,
  output ghfs_pkg::out_item_t res_a,
  output ghfs_pkg::out_item_t res_b
);
  import ghfs_pkg::*;

  typedef struct packed {
    logic signed [7:0]  status;
    logic [1:0]         kind;
    logic [4:0]         sats;
    logic signed [31:0] lat;
    logic signed [31:0] lon;
    logic signed [31:0] hgt;
  } fix_entry_t;

  function automatic logic passed(input logic [31:0] now, input logic [31:0] dl);
    logic [31:0] d;
    d = now - dl;
    return (d != 32'd0) && !d[31];
  endfunction

  logic        in_vld_r;
  in_item_t    item_r;
  logic [31:0] time_dl_r, time_dl_nxt;
  logic [31:0] fix_dl_r, fix_dl_nxt;
  logic [1:0]  step_r, step_nxt;
  logic        went_r;
  fix_entry_t  entries_r [2];
  logic [31:0] seconds_r;

  logic        fire, is_poll;
  logic        time_pass, fix_pass, cmd_seen, act;
  fix_entry_t  pub;
  logic [31:0] fix_val;
  out_item_t   time_frm, fix_frm, none_frm;

  assign fire     = in_vld_r && room;
  assign in_stall = in_vld_r && !room;
  assign is_poll  = item_r.opcode == OP_POLL;

  // published entry is the one not being written
  assign pub = entries_r[~went_r];

  assign time_pass = passed(item_r.tick_now, time_dl_r);
  assign fix_pass  = (step_r != STEP_STRAY) && passed(item_r.tick_now, fix_dl_r);
  assign cmd_seen  = item_r.rx_present && (item_r.rx_frame_id == cfg.cmd_id);
  assign act       = time_pass || fix_pass || cmd_seen;

  always_comb begin
    unique case (step_r)
      STEP_HGT: fix_val = pub.hgt;
      STEP_LON: fix_val = pub.lon;
      default:  fix_val = pub.lat;
    endcase
  end

  always_comb begin
    time_frm.frame_kind    = KIND_TIME;
    time_frm.frame_id      = cfg.time_id;
    time_frm.frame_length  = LEN_TIME;
    time_frm.frame_payload = {8'h00, seconds_r, pub.status};
    time_frm.activity      = act;
    time_frm.last          = !fix_pass;

    fix_frm.frame_kind     = KIND_FIX;
    fix_frm.frame_id       = cfg.fix_id;
    fix_frm.frame_length   = LEN_FIX;
    fix_frm.frame_payload  = {fix_val, pub.sats, 1'b0, step_r, pub.status[5:0], pub.kind};
    fix_frm.activity       = act;
    fix_frm.last           = 1'b1;

    none_frm               = '0;
    none_frm.frame_kind    = KIND_NONE;
    none_frm.frame_length  = LEN_NONE;
    none_frm.activity      = act;
    none_frm.last          = 1'b1;
  end

  // slot a takes the first frame, slot b only the fix frame behind a time frame
  always_comb begin
    res_b  = fix_frm;
    push.a = fire && is_poll;
    push.b = fire && is_poll && time_pass && fix_pass;
    priority if (time_pass) begin
      res_a = time_frm;
    end else if (fix_pass) begin
      res_a = fix_frm;
    end else begin
      res_a = none_frm;
    end
  end

  always_comb begin
    time_dl_nxt = time_dl_r;
    fix_dl_nxt  = fix_dl_r;
    step_nxt    = step_r;
    if (time_pass) begin
      time_dl_nxt = item_r.tick_now + {1'b0, cfg.time_period};
    end
    if (step_r == STEP_STRAY) begin
      step_nxt = STEP_LAT;
    end else if (fix_pass) begin
      if (step_r == STEP_HGT) begin
        fix_dl_nxt = item_r.tick_now + {1'b0, cfg.fix_period};
        step_nxt   = STEP_LAT;
      end else begin
        fix_dl_nxt = item_r.tick_now + {1'b0, cfg.fix_gap};
        step_nxt   = step_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= (in_valid && !in_stall) || (in_vld_r && !fire);
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_dl_r    <= '0;
      fix_dl_r     <= '0;
      step_r       <= STEP_LAT;
      went_r       <= 1'b0;
      entries_r[0] <= '0;
      entries_r[1] <= '0;
      seconds_r    <= '0;
    end else if (fire) begin
      unique case (item_r.opcode)
        OP_POLL: begin
          time_dl_r <= time_dl_nxt;
          fix_dl_r  <= fix_dl_nxt;
          step_r    <= step_nxt;
        end
        OP_FIX: begin
          entries_r[went_r].status <= item_r.fix_status;
          if (item_r.fix_good) begin
            entries_r[went_r].kind <= item_r.fix_kind;
            entries_r[went_r].sats <= item_r.satellites;
            entries_r[went_r].lat  <= item_r.latitude;
            entries_r[went_r].lon  <= item_r.longitude;
            entries_r[went_r].hgt  <= item_r.height;
            went_r                 <= ~went_r;
          end
        end
        OP_SECONDS: seconds_r <= item_r.seconds_count;
        default: ;
      endcase
    end
  end

endmodule

// File: hw/rtl/ghfs_queue.sv
module ghfs_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ghfs_pkg::push_t     push,
  input  ghfs_pkg::out_item_t res_a,
  input  ghfs_pkg::out_item_t res_b,
  output logic                room,
  output logic                out_valid,
  input  logic                out_stall,
  output ghfs_pkg::out_item_t out_data
);
  import ghfs_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  function automatic logic [PTR_W-1:0] inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  out_item_t        mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r, wr_ptr_b;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             pop;

  assign wr_ptr_b  = inc(wr_ptr_r);
  assign out_valid = count_r != '0;
  assign out_data  = mem_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;
  // a poll may need two slots; judged before this cycle's pop
  assign room      = ((CNT_W + 1)'(count_r) + (CNT_W + 1)'(2)) <= (CNT_W + 1)'(DEPTH);

  always_comb begin
    count_nxt = count_r + CNT_W'(push.a) + CNT_W'(push.b) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.a) begin
      mem_r[wr_ptr_r] <= res_a;
    end
    if (push.b) begin
      mem_r[wr_ptr_b] <= res_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push.b) begin
        wr_ptr_r <= inc(wr_ptr_b);
      end else if (push.a) begin
        wr_ptr_r <= wr_ptr_b;
      end
      if (pop) begin
        rd_ptr_r <= inc(rd_ptr_r);
      end
    end
  end

endmodule

// File: hw/rtl/ghfs_checker.sv
`include "gps_heartbeat_frame_scheduler_unit_defines.svh"

module ghfs_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input ghfs_pkg::out_item_t out_data
);
  import ghfs_pkg::*;

  `GHFS_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "result changed while stalled")
  `GHFS_ASSERT(a_pair_follows, out_valid && !out_stall && !out_data.last |=> out_valid, "second result of a poll missing")
  `GHFS_ASSERT(a_none_alone, out_valid && out_data.frame_kind == KIND_NONE |-> out_data.last && out_data.frame_length == LEN_NONE, "empty result malformed")
  `GHFS_ASSERT_RST(a_reset_empty, !rst_n |=> !out_valid, "results pending after reset")

endmodule

bind gps_heartbeat_frame_scheduler_unit ghfs_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// File: sim/tb.sv
module tb;
  import ghfs_pkg::*;

  // opcode 3 has no name in the package; the block drops it
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD   = 300;  // receiver hold-off, long enough to fill the result queue
  localparam int IDLE_SETTLE = 8;    // settle margin for item-free tails
  localparam int MAX_REPORTS = 10;

  // directed row: typed rows carry their own expected frames, others go through the model
  typedef struct packed {
    in_item_t   item;
    logic       typed;
    logic [1:0] n_typed;
    out_item_t  e0;
    out_item_t  e1;
  } stim_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  gps_heartbeat_frame_scheduler_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Scheduler shadow: registers, deadlines, burst step and the two-entry fix buffer
  // ---------------------------------------------------------------------------
  cfg_t        cfg_shadow;
  logic [31:0] time_dl, fix_dl;
  logic [1:0]  fstep;
  logic        wr_entry;        // entry being written; the other one is published
  logic [7:0]  st_status [2];
  logic [1:0]  st_kind   [2];
  logic [4:0]  st_sats   [2];
  logic [31:0] st_lat    [2];
  logic [31:0] st_lon    [2];
  logic [31:0] st_height [2];
  logic [31:0] secs_held;

  out_item_t   frames_due [$];  // frames the block still owes, oldest first
  stim_row_t   plan [$];        // directed rows
  logic [31:0] tick_cursor;

  bit tx_gaps = 1'b1;
  bit rx_gaps = 1'b1;
  bit hold_req = 1'b0;

  int cycle_count = 0;
  int mismatches = 0;
  int checked = 0;
  int in_backpressure = 0;
  int op_seen [4];
  int frames_by_kind [4];
  out_item_t want;

  // deadline passed: signed 32-bit difference strictly positive
  function automatic bit is_due(input logic [31:0] now, input logic [31:0] due_at);
    logic [31:0] d;
    d = now - due_at;
    return (d != 32'd0) && !d[31];
  endfunction

  function automatic out_item_t frm(input logic [1:0] kind, input logic [31:0] id,
                                    input logic [2:0] len, input logic [47:0] pay,
                                    input logic act, input logic lst);
    out_item_t f;
    f.frame_kind    = kind;
    f.frame_id      = id;
    f.frame_length  = len;
    f.frame_payload = pay;
    f.activity      = act;
    f.last          = lst;
    return f;
  endfunction

  // fix frame bytes: {value, sats, 0, step, status[5:0], kind}, byte 0 lowest
  function automatic logic [47:0] fix_bytes(input logic [1:0] step);
    logic        e;
    logic [31:0] v;
    e = ~wr_entry;
    case (step)
      STEP_HGT: v = st_height[e];
      STEP_LON: v = st_lon[e];
      default:  v = st_lat[e];
    endcase
    return {v, st_sats[e], 1'b0, step, st_status[e][5:0], st_kind[e]};
  endfunction

  // advances the shadow by one item and returns the frames it emits
  task automatic schedule_frames(input in_item_t it, output int n,
                                 output out_item_t r0, output out_item_t r1);
    out_item_t got [2];
    logic      pub;
    logic      act;
    n = 0;
    act = 1'b0;
    pub = ~wr_entry;
    got[0] = '0;
    got[1] = '0;
    case (it.opcode)
      OP_FIX: begin
        st_status[wr_entry] = it.fix_status;
        if (it.fix_good) begin
          st_kind[wr_entry]   = it.fix_kind;
          st_sats[wr_entry]   = it.satellites;
          st_lat[wr_entry]    = it.latitude;
          st_lon[wr_entry]    = it.longitude;
          st_height[wr_entry] = it.height;
          wr_entry = ~wr_entry;
        end
      end
      OP_SECONDS: secs_held = it.seconds_count;
      OP_POLL: begin
        if (is_due(it.tick_now, time_dl)) begin
          got[n] = frm(KIND_TIME, cfg_shadow.time_id, LEN_TIME,
                       {8'h00, secs_held, st_status[pub]}, 1'b0, 1'b0);
          n++;
          time_dl = it.tick_now + {1'b0, cfg_shadow.time_period};
          act = 1'b1;
        end
        if (fstep == STEP_STRAY) begin
          fstep = STEP_LAT;
        end else if (is_due(it.tick_now, fix_dl)) begin
          got[n] = frm(KIND_FIX, cfg_shadow.fix_id, LEN_FIX, fix_bytes(fstep), 1'b0, 1'b0);
          n++;
          if (fstep == STEP_HGT) begin
            fix_dl = it.tick_now + {1'b0, cfg_shadow.fix_period};
            fstep = STEP_LAT;
          end else begin
            fix_dl = it.tick_now + {1'b0, cfg_shadow.fix_gap};
            fstep = fstep + 2'd1;
          end
          act = 1'b1;
        end
        // a matching command id only marks activity
        if (it.rx_present && it.rx_frame_id == cfg_shadow.cmd_id) act = 1'b1;
        if (n == 0) begin
          got[0] = frm(KIND_NONE, '0, LEN_NONE, '0, 1'b0, 1'b0);
          n = 1;
        end
        for (int k = 0; k < n; k++) begin
          got[k].activity = act;
          got[k].last = (k == n - 1);
        end
      end
      default: ;
    endcase
    r0 = got[0];
    r1 = got[1];
  endtask

  // ---------------------------------------------------------------------------
  // Item builders for the directed table
  // ---------------------------------------------------------------------------
  function automatic in_item_t poll_at(input logic [31:0] tick, input logic rxp,
                                       input logic [31:0] rxid);
    in_item_t it;
    it = '0;
    it.opcode = OP_POLL;
    it.tick_now = tick;
    it.rx_present = rxp;
    it.rx_frame_id = rxid;
    return it;
  endfunction

  function automatic in_item_t fix_upd(input logic good, input logic [7:0] st,
                                       input logic [1:0] kind, input logic [4:0] sats,
                                       input logic [31:0] la, input logic [31:0] lo,
                                       input logic [31:0] hg);
    in_item_t it;
    it = '0;
    it.opcode = OP_FIX;
    it.fix_good = good;
    it.fix_status = st;
    it.fix_kind = kind;
    it.satellites = sats;
    it.latitude = la;
    it.longitude = lo;
    it.height = hg;
    return it;
  endfunction

  function automatic in_item_t secs_upd(input logic [31:0] s);
    in_item_t it;
    it = '0;
    it.opcode = OP_SECONDS;
    it.seconds_count = s;
    return it;
  endfunction

  function automatic void add_row(input in_item_t it, input logic typed, input logic [1:0] n,
                                  input out_item_t e0, input out_item_t e1);
    stim_row_t r;
    r.item = it;
    r.typed = typed;
    r.n_typed = n;
    r.e0 = e0;
    r.e1 = e1;
    plan.push_back(r);
  endfunction

  // random item; polls walk a tick cursor so deadlines pass at a useful rate
  function automatic in_item_t pick_item(input bit polls_only, input logic [31:0] step_max);
    in_item_t    it;
    logic [31:0] rnd;
    int unsigned roll;
    int unsigned walk;
    rnd = $urandom;
    it.opcode = OP_POLL;
    it.tick_now = $urandom;
    it.rx_present = rnd[15];
    it.rx_frame_id = $urandom;
    it.fix_good = rnd[16];
    it.fix_status = rnd[7:0];
    it.fix_kind = rnd[9:8];
    it.satellites = rnd[14:10];
    it.latitude = $urandom;
    it.longitude = $urandom;
    it.height = $urandom;
    it.seconds_count = $urandom;
    roll = polls_only ? 0 : $urandom_range(0, 99);
    if (roll < 68) begin
      walk = $urandom_range(0, 99);
      if (walk < 85) tick_cursor = tick_cursor + $urandom_range(0, step_max);
      else if (walk < 92) tick_cursor = $urandom;
      else if (walk < 96) tick_cursor = tick_cursor - $urandom_range(0, step_max);
      else tick_cursor = tick_cursor + 32'h7FFF_FFF0 + $urandom_range(0, 32);
      it.tick_now = tick_cursor;
      if (rnd[20:19] == 2'b00) it.rx_frame_id = cfg_shadow.cmd_id;
    end else if (roll < 84) begin
      it.opcode = OP_FIX;
      it.fix_good = (rnd[17:16] != 2'b00);
    end else if (roll < 95) begin
      it.opcode = OP_SECONDS;
    end else begin
      it.opcode = OP_UNUSED;
    end
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: one transfer per call; valid stays up into the next call
  // ---------------------------------------------------------------------------
  task automatic send_item(input stim_row_t row);
    int        n;
    out_item_t r0, r1;
    if (tx_gaps && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= row.item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    schedule_frames(row.item, n, r0, r1);
    if (row.typed) begin
      n = row.n_typed;
      r0 = row.e0;
      r1 = row.e1;
    end
    if (n > 0) frames_due.push_back(r0);
    if (n > 1) frames_due.push_back(r1);
    op_seen[row.item.opcode]++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
  endtask

  // counts only items the block acts on
  task automatic run_items(input int count, input logic [31:0] step_max, input bit polls_only);
    stim_row_t row;
    int done;
    done = 0;
    while (done < count) begin
      row = '0;
      row.item = pick_item(polls_only, step_max);
      send_item(row);
      if (row.item.opcode != OP_UNUSED) done++;
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_TIME_ID:     cfg_shadow.time_id = val;
      REG_FIX_ID:      cfg_shadow.fix_id = val;
      REG_CMD_ID:      cfg_shadow.cmd_id = val;
      REG_TIME_PERIOD: cfg_shadow.time_period = val[30:0];
      REG_FIX_PERIOD:  cfg_shadow.fix_period = val[30:0];
      REG_FIX_GAP:     cfg_shadow.fix_gap = val[30:0];
      default: ;
    endcase
  endtask

  // register writes only on an idle block: all frames back, then a settle margin
  task automatic program_regs(input logic [31:0] tid, input logic [31:0] fid,
                              input logic [31:0] cid, input logic [31:0] tper,
                              input logic [31:0] fper, input logic [31:0] gap);
    drain_results();
    repeat (IDLE_SETTLE) @(posedge clk);
    write_reg(REG_TIME_ID, tid);
    write_reg(REG_FIX_ID, fid);
    write_reg(REG_CMD_ID, cid);
    write_reg(REG_TIME_PERIOD, tper);
    write_reg(REG_FIX_PERIOD, fper);
    write_reg(REG_FIX_GAP, gap);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall bursts, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // every result transfer is matched against the oldest frame still due
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (in_valid && in_stall === 1'b1) in_backpressure++;
      if (out_valid === 1'b1 && !out_stall) begin
        if (frames_due.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("[%0d] result with nothing due: kind=%0d id=%h len=%0d pay=%h act=%b last=%b",
                     cycle_count, out_data.frame_kind, out_data.frame_id,
                     out_data.frame_length, out_data.frame_payload,
                     out_data.activity, out_data.last);
        end else begin
          want = frames_due.pop_front();
          checked++;
          frames_by_kind[want.frame_kind]++;
          if (out_data.frame_kind !== want.frame_kind || out_data.frame_id !== want.frame_id ||
              out_data.frame_length !== want.frame_length ||
              out_data.frame_payload !== want.frame_payload ||
              out_data.activity !== want.activity || out_data.last !== want.last) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("[%0d] frame mismatch", cycle_count);
              $display("  exp kind=%0d id=%h len=%0d pay=%h act=%b last=%b",
                       want.frame_kind, want.frame_id, want.frame_length,
                       want.frame_payload, want.activity, want.last);
              $display("  got kind=%0d id=%h len=%0d pay=%h act=%b last=%b",
                       out_data.frame_kind, out_data.frame_id, out_data.frame_length,
                       out_data.frame_payload, out_data.activity, out_data.last);
            end
          end
        end
      end
    end
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d frames still due", cycle_count, frames_due.size());
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    in_item_t junk;
    int dir_split;

    // shadow starts from the reset state
    cfg_shadow = '0;
    time_dl = '0;
    fix_dl = '0;
    fstep = STEP_LAT;
    wr_entry = 1'b0;
    secs_held = '0;
    tick_cursor = '0;
    for (int i = 0; i < 2; i++) begin
      st_status[i] = '0;
      st_kind[i] = '0;
      st_sats[i] = '0;
      st_lat[i] = '0;
      st_lon[i] = '0;
      st_height[i] = '0;
    end

    // Directed rows on reset registers (all ids and periods zero).
    // Tick equal to the deadline, or half the range away, is not yet due.
    add_row(poll_at(32'h0, 1'b1, 32'h0), 1'b1, 2'd1,
            frm(KIND_NONE, '0, LEN_NONE, '0, 1'b1, 1'b1), '0);  // command id 0 matches
    add_row(poll_at(32'h8000_0000, 1'b0, '1), 1'b1, 2'd1,
            frm(KIND_NONE, '0, LEN_NONE, '0, 1'b0, 1'b1), '0);
    add_row(poll_at('1, 1'b1, '1), 1'b1, 2'd1,
            frm(KIND_NONE, '0, LEN_NONE, '0, 1'b0, 1'b1), '0);
    add_row(secs_upd('1), 1'b1, 2'd0, '0, '0);
    // failed fix: only status of the working entry; published entry untouched
    add_row(fix_upd(1'b0, 8'h80, 2'd2, 5'd9, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F),
            1'b1, 2'd0, '0, '0);
    // both deadlines pass: time frame first, then latitude
    add_row(poll_at(32'h1, 1'b0, 32'h0), 1'b1, 2'd2,
            frm(KIND_TIME, '0, LEN_TIME, 48'h00FF_FFFF_FF00, 1'b1, 1'b0),
            frm(KIND_FIX, '0, LEN_FIX, 48'h0, 1'b1, 1'b1));
    // good fix at the field extremes flips the published entry
    add_row(fix_upd(1'b1, 8'h7F, 2'd3, 5'd31, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF),
            1'b1, 2'd0, '0, '0);
    add_row(poll_at(32'h2, 1'b0, 32'h0), 1'b1, 2'd2,
            frm(KIND_TIME, '0, LEN_TIME, 48'h00FF_FFFF_FF7F, 1'b1, 1'b0),
            frm(KIND_FIX, '0, LEN_FIX, 48'h7FFF_FFFF_F9FF, 1'b1, 1'b1));
    add_row(poll_at(32'h3, 1'b0, 32'h0), 1'b0, 2'd0, '0, '0);  // height, burst wraps
    add_row(poll_at(32'h4, 1'b0, 32'h0), 1'b0, 2'd0, '0, '0);
    junk = '1;
    junk.opcode = OP_UNUSED;
    add_row(junk, 1'b1, 2'd0, '0, '0);                          // dropped, no result
    add_row(poll_at(32'h4, 1'b1, 32'h0), 1'b1, 2'd1,
            frm(KIND_NONE, '0, LEN_NONE, '0, 1'b1, 1'b1), '0);  // same tick, command only
    add_row(secs_upd(32'h0), 1'b0, 2'd0, '0, '0);
    dir_split = plan.size();
    // rows below run with every register at its maximum
    add_row(poll_at(32'h5, 1'b0, 32'h0), 1'b0, 2'd0, '0, '0);
    add_row(poll_at(32'h8000_0004, 1'b1, '1), 1'b0, 2'd0, '0, '0);
    add_row(fix_upd(1'b1, 8'hFF, 2'd0, 5'd0, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF),
            1'b0, 2'd0, '0, '0);
    add_row(fix_upd(1'b0, 8'h00, 2'd1, 5'd16, 32'h5555_AAAA, 32'hAAAA_5555, 32'h1),
            1'b0, 2'd0, '0, '0);
    add_row(poll_at(32'h8000_0005, 1'b1, 32'hFFFF_FFFE), 1'b0, 2'd0, '0, '0);
    add_row(poll_at(32'h5, 1'b0, 32'h0), 1'b0, 2'd0, '0, '0);  // time and fix both due

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (i == dir_split) program_regs('1, '1, '1, '1, '1, '1);
      send_item(plan[i]);
    end

    // Phase A: moderate periods, slow tick walk
    program_regs($urandom, $urandom, $urandom, 32'd10, 32'd40, 32'd3);
    tick_cursor = 32'h100;
    run_items(150, 32'd8, 1'b0);
    // receiver holds off while polls keep coming: the result queue fills and input stalls
    tx_gaps = 1'b0;
    hold_req = 1'b1;
    run_items(40, 32'd8, 1'b1);
    tx_gaps = 1'b1;
    run_items(200, 32'd8, 1'b0);

    // Phase B: zero ids and periods; a poll is due once its tick passes that of the last due poll
    program_regs(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    tick_cursor = $urandom;
    run_items(150, 32'd3, 1'b0);
    drain_results();  // sender waits for every frame before going on
    run_items(240, 32'd3, 1'b0);

    // Phase C: top periods, deadlines only pass on large tick jumps
    program_regs('1, '1, '1, '1, '1, '1);
    tick_cursor = 32'h0;
    run_items(390, 32'h6000_0000, 1'b0);

    // Phase D: random settings, tick starts just below the wrap
    program_regs($urandom, $urandom, $urandom, $urandom_range(0, 60),
                 $urandom_range(0, 120), $urandom_range(0, 12));
    tick_cursor = 32'hFFFF_FF80;
    run_items(140, 32'd20, 1'b0);
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    run_items(250, 32'd20, 1'b0);

    drain_results();
    repeat (IDLE_SETTLE) @(posedge clk);

    $display("items: %0d polls, %0d fix updates, %0d seconds updates, %0d unused opcodes",
             op_seen[OP_POLL], op_seen[OP_FIX], op_seen[OP_SECONDS], op_seen[OP_UNUSED]);
    $display("frames checked: %0d (%0d time, %0d fix, %0d empty), input held %0d cycles, %0d bad",
             checked, frames_by_kind[KIND_TIME], frames_by_kind[KIND_FIX],
             frames_by_kind[KIND_NONE], in_backpressure, mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/ghfs_pkg.sv
hw/rtl/ghfs_regs.sv
hw/rtl/ghfs_core.sv
hw/rtl/ghfs_queue.sv
hw/rtl/gps_heartbeat_frame_scheduler_unit.sv
hw/rtl/ghfs_checker.sv
sim/tb.sv
